>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge; off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg
// Types, register indexes and reset values for the sensor trend alarm.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sta_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 12;
    localparam int CFG_W     = 12;
    localparam int HOLD_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_W-1:0]  RST_START_LEVEL   = 12'd2300;
    localparam logic [CFG_W-1:0]  RST_ALARM_LEVEL   = 12'd3600;
    localparam logic [CFG_W-1:0]  RST_RELEASE_LEVEL = 12'd3100;
    localparam logic [CFG_W-1:0]  RST_STEP_LIMIT    = 12'd100;
    localparam logic [CFG_W-1:0]  RST_RELEASE_DROP  = 12'd300;
    localparam logic [HOLD_W-1:0] RST_HOLD_SAMPLES  = 16'd200;

    localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DROP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES  = 3'd5;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_RISING = 2'd1,
        MODE_ALARM  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_START     = 3'd1,
        EV_STOP      = 3'd2,
        EV_ALARM_ON  = 3'd3,
        EV_NONLINEAR = 3'd4,
        EV_ALARM_OFF = 3'd5
    } event_t;

    typedef struct packed {
        logic [CFG_W-1:0]  start_level;
        logic [CFG_W-1:0]  alarm_level;
        logic [CFG_W-1:0]  release_level;
        logic [CFG_W-1:0]  step_limit;
        logic [CFG_W-1:0]  release_drop;
        logic [HOLD_W-1:0] hold_samples;
    } cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic [HOLD_W-1:0] run_count;
        logic              buzzer;
    } state_t;

endpackage

`default_nettype wire

>>> design/sta_step.sv
// ----------------------------------------------------------------------------
// sta_step
// Next-state and event logic for one sample of the trend alarm FSM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sta_step #(
    parameter int SAMPLE_BITS = sta_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire sta_pkg::cfg_t     cfg,
    input  wire sta_pkg::state_t   state,
    input  wire [SAMPLE_BITS-1:0]  prev,
    input  wire [SAMPLE_BITS-1:0]  sample,
    output sta_pkg::state_t        state_next,
    output sta_pkg::event_t        event_next
);

    // One spare bit above the wider operand: sums never wrap, all compares unsigned
    localparam int CW = ((SAMPLE_BITS > sta_pkg::CFG_W) ? SAMPLE_BITS : sta_pkg::CFG_W) + 1;

    logic [CW-1:0] s_x;
    logic [CW-1:0] p_x;
    logic [CW-1:0] lo_x;
    logic [CW-1:0] up_x;
    logic [CW-1:0] rl_x;
    logic [CW-1:0] st_x;
    logic [CW-1:0] rd_x;
    logic          stop_run;
    logic          start_run;
    logic          release_hit;
    logic [sta_pkg::HOLD_W-1:0] count_inc;

    assign s_x  = CW'(sample);
    assign p_x  = CW'(prev);
    assign lo_x = CW'(cfg.start_level);
    assign up_x = CW'(cfg.alarm_level);
    assign rl_x = CW'(cfg.release_level);
    assign st_x = CW'(cfg.step_limit);
    assign rd_x = CW'(cfg.release_drop);

    // s <= p - st  is rewritten as  s + st <= p
    assign stop_run    = (s_x + st_x <= p_x) || (s_x >= p_x + st_x) || (s_x <= lo_x);
    assign start_run   = (s_x > lo_x) && (s_x < lo_x + st_x);
    assign release_hit = (s_x + rd_x < p_x) && (s_x <= rl_x);
    assign count_inc   = state.run_count + 1'b1;

    always_comb
    begin
        state_next = state;
        event_next = sta_pkg::EV_NONE;
        unique case (state.mode)
            sta_pkg::MODE_RISING:
            begin
                if (stop_run)
                begin
                    state_next.mode = sta_pkg::MODE_IDLE;
                    event_next      = sta_pkg::EV_STOP;
                end
                else
                begin
                    state_next.run_count = count_inc;
                    if (count_inc == cfg.hold_samples)
                    begin
                        if (s_x > up_x)
                        begin
                            state_next.mode   = sta_pkg::MODE_ALARM;
                            state_next.buzzer = 1'b1;
                            event_next        = sta_pkg::EV_ALARM_ON;
                        end
                        else
                        begin
                            state_next.mode = sta_pkg::MODE_IDLE;
                            event_next      = sta_pkg::EV_NONLINEAR;
                        end
                    end
                end
            end
            sta_pkg::MODE_ALARM:
            begin
                if (release_hit)
                begin
                    state_next.mode   = sta_pkg::MODE_IDLE;
                    state_next.buzzer = 1'b0;
                    event_next        = sta_pkg::EV_ALARM_OFF;
                end
            end
            default:
            begin
                // idle, and the unused code, which behaves as idle
                state_next.run_count = '0;
                state_next.mode      = sta_pkg::MODE_IDLE;
                if (start_run)
                begin
                    state_next.mode = sta_pkg::MODE_RISING;
                    event_next      = sta_pkg::EV_START;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/sensor_trend_alarm_fsm.sv
// Path: an accepted sample is registered in the input stage, then moves on to the
//   result registers as the FSM state updates; the result is taken when not stalled.
// Throughput: one sample per cycle while the result port is not stalled.
// The input stalls only while input and result registers are full and out_stall is high.
// Reset: mode idle, run count, previous sample and buzzer zero, registers at
//   their defaults, both stages empty.
// ----------------------------------------------------------------------------
// sensor_trend_alarm_fsm
// ADC trend watcher: tracks rising runs of samples and drives an alarm buzzer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sensor_trend_alarm_fsm #(
    parameter int SAMPLE_BITS = sta_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire                              clk,
    input  wire                              rst_n,

    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [sta_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [sta_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire [SAMPLE_BITS-1:0]            sample,

    output logic                             out_valid,
    input  wire                              out_stall,
    output logic                             buzzer,
    output logic [1:0]                       mode,
    output logic [2:0]                       event_res
);

    sta_pkg::cfg_t    cfg_reg;
    sta_pkg::state_t  state_reg;
    sta_pkg::state_t  state_next;
    sta_pkg::event_t  event_next;
    logic [SAMPLE_BITS-1:0] prev_reg;

    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;

    logic              out_valid_reg;
    logic              out_buzzer_reg;
    sta_pkg::mode_t    out_mode_reg;
    sta_pkg::event_t   out_event_reg;

    logic out_free;
    logic s1_move;
    logic in_accept;

    assign cfg_ready = 1'b1;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_level   <= sta_pkg::RST_START_LEVEL;
            cfg_reg.alarm_level   <= sta_pkg::RST_ALARM_LEVEL;
            cfg_reg.release_level <= sta_pkg::RST_RELEASE_LEVEL;
            cfg_reg.step_limit    <= sta_pkg::RST_STEP_LIMIT;
            cfg_reg.release_drop  <= sta_pkg::RST_RELEASE_DROP;
            cfg_reg.hold_samples  <= sta_pkg::RST_HOLD_SAMPLES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sta_pkg::REG_START_LEVEL:
                    cfg_reg.start_level <= cfg_data[sta_pkg::CFG_W-1:0];
                sta_pkg::REG_ALARM_LEVEL:
                    cfg_reg.alarm_level <= cfg_data[sta_pkg::CFG_W-1:0];
                sta_pkg::REG_RELEASE_LEVEL:
                    cfg_reg.release_level <= cfg_data[sta_pkg::CFG_W-1:0];
                sta_pkg::REG_STEP_LIMIT:
                    cfg_reg.step_limit <= cfg_data[sta_pkg::CFG_W-1:0];
                sta_pkg::REG_RELEASE_DROP:
                    cfg_reg.release_drop <= cfg_data[sta_pkg::CFG_W-1:0];
                sta_pkg::REG_HOLD_SAMPLES:
                    cfg_reg.hold_samples <= cfg_data[sta_pkg::HOLD_W-1:0];
                default:
                begin
                    // writes past the last register are dropped
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= sample;
        end
    end

    sta_step #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .prev       (prev_reg),
        .sample     (s1_sample_reg),
        .state_next (state_next),
        .event_next (event_next)
    );

    // FSM state: updated as each sample leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode      <= sta_pkg::MODE_IDLE;
            state_reg.run_count <= '0;
            state_reg.buzzer    <= 1'b0;
            prev_reg            <= '0;
        end
        else if (s1_move)
        begin
            state_reg <= state_next;
            prev_reg  <= s1_sample_reg;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_buzzer_reg <= state_next.buzzer;
            out_mode_reg   <= state_next.mode;
            out_event_reg  <= event_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign buzzer    = out_buzzer_reg;
    assign mode      = out_mode_reg;
    assign event_res = out_event_reg;

    `ASSERT_CLK(a_buzzer_tracks_alarm, clk, rst_n,
        (state_reg.buzzer == (state_reg.mode == sta_pkg::MODE_ALARM)),
        "buzzer state disagrees with alarm mode")
    `ASSERT_CLK(a_alarm_on_result, clk, rst_n,
        (out_valid_reg && out_event_reg == sta_pkg::EV_ALARM_ON) |->
            (out_buzzer_reg && out_mode_reg == sta_pkg::MODE_ALARM),
        "alarm-on transaction without alarm mode and buzzer")
    `ASSERT_CLK(a_stall_only_when_full, clk, rst_n,
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall),
        "input stalled while a stage has room")

endmodule

`default_nettype wire

>>> dv/sensor_trend_alarm_fsm_tb.sv
// ----------------------------------------------------------------------------
// sensor_trend_alarm_fsm_tb
// Self-checking bench for the ADC trend alarm FSM. A state-aware generator
// builds rising runs, alarm raises and releases with random content, plus
// noise. Each accepted sample transaction is run through a local model; each
// result transaction is checked field by field against the oldest prediction.
// Phases cover several register settings and several idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_trend_alarm_fsm_tb;

    localparam int SW        = sta_pkg::SAMPLE_BITS_DEFAULT;
    localparam int SMAX      = (1 << SW) - 1;
    localparam int LIMIT     = 100000;
    localparam int LONG_HOLD = 300;
    localparam int IDX_W     = sta_pkg::CFG_IDX_W;
    localparam int DATA_W    = sta_pkg::CFG_DATA_W;

    // indexes past the register map; writes there must be ignored
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        sta_pkg::mode_t             mode;
        logic [sta_pkg::HOLD_W-1:0] run;
        logic [SW-1:0]              prev;
        logic                       buzzer;
    } trend_state_t;

    typedef struct packed {
        logic            buzzer;
        sta_pkg::mode_t  mode;
        sta_pkg::event_t ev;
    } alarm_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [SW-1:0]     sample = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              buzzer;
    logic [1:0]        mode;
    logic [2:0]        event_res;

    logic [SW-1:0]  adc_sample_q[$];
    alarm_result_t  alarm_results_q[$];

    sta_pkg::cfg_t  dut_cfg;
    trend_state_t   dut_trend;
    sta_pkg::cfg_t  gen_cfg;
    trend_state_t   gen_trend;
    bit             gen_aim_alarm;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;

    sensor_trend_alarm_fsm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .buzzer    (buzzer),
        .mode      (mode),
        .event_res (event_res)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void apply_reg(inout sta_pkg::cfg_t c,
                                      input logic [IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] d);
        case (idx)
            sta_pkg::REG_START_LEVEL:   c.start_level   = d[sta_pkg::CFG_W-1:0];
            sta_pkg::REG_ALARM_LEVEL:   c.alarm_level   = d[sta_pkg::CFG_W-1:0];
            sta_pkg::REG_RELEASE_LEVEL: c.release_level = d[sta_pkg::CFG_W-1:0];
            sta_pkg::REG_STEP_LIMIT:    c.step_limit    = d[sta_pkg::CFG_W-1:0];
            sta_pkg::REG_RELEASE_DROP:  c.release_drop  = d[sta_pkg::CFG_W-1:0];
            sta_pkg::REG_HOLD_SAMPLES:  c.hold_samples  = d[sta_pkg::HOLD_W-1:0];
            default: ;
        endcase
    endfunction

    // One sample through the trend FSM; all compares in int so nothing wraps.
    function automatic alarm_result_t predict_alarm_step(inout trend_state_t st,
                                                         input sta_pkg::cfg_t c,
                                                         input logic [SW-1:0] s_in);
        int s;
        int p;
        int lo;
        int stp;
        alarm_result_t r;
        s   = s_in;
        p   = st.prev;
        lo  = c.start_level;
        stp = c.step_limit;
        r.ev = sta_pkg::EV_NONE;
        case (st.mode)
            sta_pkg::MODE_RISING:
            begin
                if (s <= p - stp || s >= p + stp || s <= lo)
                begin
                    st.mode = sta_pkg::MODE_IDLE;
                    r.ev = sta_pkg::EV_STOP;
                end
                else
                begin
                    st.run = st.run + 1'b1;
                    if (st.run == c.hold_samples)
                    begin
                        if (s > int'(c.alarm_level))
                        begin
                            st.mode = sta_pkg::MODE_ALARM;
                            st.buzzer = 1'b1;
                            r.ev = sta_pkg::EV_ALARM_ON;
                        end
                        else
                        begin
                            st.mode = sta_pkg::MODE_IDLE;
                            r.ev = sta_pkg::EV_NONLINEAR;
                        end
                    end
                end
            end
            sta_pkg::MODE_ALARM:
            begin
                if (s + int'(c.release_drop) < p && s <= int'(c.release_level))
                begin
                    st.mode = sta_pkg::MODE_IDLE;
                    st.buzzer = 1'b0;
                    r.ev = sta_pkg::EV_ALARM_OFF;
                end
            end
            default:
            begin
                st.mode = sta_pkg::MODE_IDLE;
                st.run = '0;
                if (s > lo && s < lo + stp)
                begin
                    st.mode = sta_pkg::MODE_RISING;
                    r.ev = sta_pkg::EV_START;
                end
            end
        endcase
        st.prev = s_in;
        r.buzzer = st.buzzer;
        r.mode = st.mode;
        return r;
    endfunction

    // Next sample from the generator's view of the FSM: mostly well-formed runs.
    function automatic logic [SW-1:0] pick_sample(input int noise_pct);
        int p;
        int lo;
        int stp;
        int lo_s;
        int hi_s;
        int d;
        int need;
        int top;
        p   = gen_trend.prev;
        lo  = gen_cfg.start_level;
        stp = gen_cfg.step_limit;
        if ($urandom_range(99) < noise_pct)
            return SW'($urandom_range(SMAX));
        case (gen_trend.mode)
            sta_pkg::MODE_RISING:
            begin
                lo_s = (p - stp + 1 > lo + 1) ? p - stp + 1 : lo + 1;
                hi_s = (p + stp - 1 < SMAX) ? p + stp - 1 : SMAX;
                if (lo_s > hi_s)
                    return SW'($urandom_range(SMAX));
                // steady samples left before the hold decision
                d = int'(gen_cfg.hold_samples) - int'(gen_trend.run);
                if (d <= 0)
                    d += 65536;
                need = int'(gen_cfg.alarm_level) + 1 - p;
                if (gen_aim_alarm && need > 0)
                begin
                    top = p + (need + d - 1) / d;
                    if (top > hi_s)
                        top = hi_s;
                    if (top > lo_s)
                        lo_s = top;
                end
                else if (!gen_aim_alarm && d == 1 && hi_s > int'(gen_cfg.alarm_level)
                         && int'(gen_cfg.alarm_level) >= lo_s)
                    hi_s = gen_cfg.alarm_level;
                return SW'($urandom_range(hi_s, lo_s));
            end
            sta_pkg::MODE_ALARM:
            begin
                d = $urandom_range(7);
                top = p - int'(gen_cfg.release_drop) - 1;
                if (top > int'(gen_cfg.release_level))
                    top = gen_cfg.release_level;
                if (d < 2 && top >= 0)
                    return SW'($urandom_range(top, 0));
                if (d == 2)
                    return SW'($urandom_range(SMAX));
                lo_s = p - int'(gen_cfg.release_drop);
                hi_s = p + int'(gen_cfg.release_drop);
                return SW'($urandom_range(hi_s > SMAX ? SMAX : hi_s, lo_s < 0 ? 0 : lo_s));
            end
            default:
            begin
                hi_s = lo + stp - 1;
                if (hi_s > SMAX)
                    hi_s = SMAX;
                if (hi_s < lo + 1)
                    return SW'($urandom_range(SMAX));
                gen_aim_alarm = 1'($urandom_range(1));
                return SW'($urandom_range(hi_s, lo + 1));
            end
        endcase
    endfunction

    task automatic push_sample(input logic [SW-1:0] s);
        adc_sample_q.push_back(s);
        void'(predict_alarm_step(gen_trend, gen_cfg, s));
    endtask

    task automatic gen_samples(input int n, input int noise_pct);
        @(negedge clk);
        repeat (n) push_sample(pick_sample(noise_pct));
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (adc_sample_q.size() != 0 || in_valid || alarm_results_q.size() != 0);
    endtask

    // 12-bit registers get random upper data bits, which must be dropped
    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        logic [DATA_W-1:0] d;
        d = value[DATA_W-1:0];
        if (idx != sta_pkg::REG_HOLD_SAMPLES)
            d[DATA_W-1:sta_pkg::CFG_W] = 4'($urandom_range(15));
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(gen_cfg, idx, d);
    endtask

    task automatic write_all(input int lo, input int up, input int rel, input int stp,
                             input int drop, input int hold);
        write_reg(sta_pkg::REG_START_LEVEL, lo);
        write_reg(sta_pkg::REG_ALARM_LEVEL, up);
        write_reg(sta_pkg::REG_RELEASE_LEVEL, rel);
        write_reg(sta_pkg::REG_STEP_LIMIT, stp);
        write_reg(sta_pkg::REG_RELEASE_DROP, drop);
        write_reg(sta_pkg::REG_HOLD_SAMPLES, hold);
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (adc_sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                sample <= adc_sample_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result stall: random, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (hold_reqs != hold_seen)
            begin
                hold_seen <= hold_reqs;
                hold_left <= LONG_HOLD;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
            out_stall <= (hold_reqs != hold_seen) || (hold_left > 1)
                         || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: register shadow, prediction on input, check on output
    always @(posedge clk)
    begin
        alarm_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(dut_cfg, cfg_index, cfg_data);
            if (out_valid && !out_stall)
            begin
                if (alarm_results_q.size() == 0)
                    report_mismatch("result transaction with nothing expected");
                else
                begin
                    want = alarm_results_q.pop_front();
                    if (buzzer !== want.buzzer)
                        report_mismatch($sformatf("buzzer %b, expected %b",
                                                  buzzer, want.buzzer));
                    if (mode !== want.mode)
                        report_mismatch($sformatf("mode %0d, expected %s",
                                                  mode, want.mode.name()));
                    if (event_res !== want.ev)
                        report_mismatch($sformatf("event %0d, expected %s",
                                                  event_res, want.ev.name()));
                end
            end
            if (in_valid && !in_stall)
                alarm_results_q.push_back(predict_alarm_step(dut_trend, dut_cfg, sample));
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("sensor_trend_alarm_fsm_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        dut_cfg = '{sta_pkg::RST_START_LEVEL, sta_pkg::RST_ALARM_LEVEL,
                    sta_pkg::RST_RELEASE_LEVEL, sta_pkg::RST_STEP_LIMIT,
                    sta_pkg::RST_RELEASE_DROP, sta_pkg::RST_HOLD_SAMPLES};
        gen_cfg = dut_cfg;
        dut_trend = '{sta_pkg::MODE_IDLE, '0, '0, 1'b0};
        gen_trend = dut_trend;
        gen_aim_alarm = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings: field extremes and start window edges
        @(negedge clk);
        push_sample(0);
        push_sample(SMAX);
        push_sample(2300);   // at start level: no start
        push_sample(2400);   // at start level + step: no start
        push_sample(2301);   // start
        push_sample(2401);   // stop, step up hits the limit
        push_sample(2399);   // start
        push_sample(2300);   // stop, back to start level
        push_sample(2350);   // start
        push_sample(2250);   // stop, step down hits the limit
        push_sample(2350);   // start, left running into the next settings
        write_reg(sta_pkg::REG_HOLD_SAMPLES, 3);
        write_reg(sta_pkg::REG_ALARM_LEVEL, 2400);
        @(negedge clk);
        push_sample(2300);   // stop the leftover run
        push_sample(2310);
        push_sample(2350);
        push_sample(2390);
        push_sample(2420);   // alarm on
        push_sample(2120);   // drop equals release drop: alarm stays
        push_sample(1819);   // alarm off
        push_sample(2310);
        push_sample(2320);
        push_sample(2330);
        push_sample(2340);   // decision at or below alarm level: not linear

        write_all(1000, 1400, 1200, 100, 150, 8);
        set_idling(0, 0);
        gen_samples(200, 10);

        // widest window, single-sample hold, alarm unreachable
        write_all(0, SMAX, SMAX, SMAX, 0, 1);
        set_idling(73, 0);
        gen_samples(150, 10);

        // start level at top: nothing can start; spare indexes ignored
        write_reg(sta_pkg::REG_START_LEVEL, SMAX);
        write_reg(sta_pkg::REG_STEP_LIMIT, 50);
        write_reg(REG_SPARE_LO, $urandom_range(16'hFFFF));
        write_reg(REG_SPARE_HI, $urandom_range(16'hFFFF));
        set_idling(0, 73);
        gen_samples(50, 20);

        // release only from a drop to zero
        write_all(500, 700, 0, 60, 0, 5);
        set_idling(38, 38);
        gen_samples(200, 10);

        // zero step limit: empty start window
        write_reg(sta_pkg::REG_START_LEVEL, 100);
        write_reg(sta_pkg::REG_STEP_LIMIT, 0);
        set_idling(73, 0);
        gen_samples(50, 30);

        // alarm level zero, release drop never met: alarm sticks
        write_all(50, 0, 3000, 200, SMAX, 3);
        set_idling(0, 73);
        gen_samples(150, 10);

        // long receiver hold-off while the sender keeps offering
        write_all(1000, 1300, 2000, 80, 100, 6);
        set_idling(0, 0);
        gen_samples(200, 10);
        hold_reqs = hold_reqs + 1;

        // hold count zero: a run keeps counting with no decision in sight
        write_all(1000, 1500, 1200, 100, 150, 0);
        set_idling(0, 0);
        gen_samples(100, 0);

        // hold lowered below the running count mid-run
        write_reg(sta_pkg::REG_HOLD_SAMPLES, 20);
        write_reg(sta_pkg::REG_START_LEVEL, 1000);
        gen_samples(11, 0);
        write_reg(sta_pkg::REG_HOLD_SAMPLES, 5);
        gen_samples(60, 0);

        for (int k = 0; k < 6; k++)
        begin
            int lo;
            lo = $urandom_range(3000);
            write_all(lo, lo + $urandom_range(600), $urandom_range(SMAX),
                      $urandom_range(300, 1), $urandom_range(500), $urandom_range(30, 1));
            case (k % 4)
                0: set_idling(0, 0);
                1: set_idling(73, 0);
                2: set_idling(0, 73);
                default: set_idling(38, 38);
            endcase
            gen_samples(80, 15);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("sensor_trend_alarm_fsm_tb: done, clean");
        else
            $display("sensor_trend_alarm_fsm_tb: done, errors");
        $finish;
    end

endmodule
